// ----- src/rrg_pkg.sv -----
package rrg_pkg;

    // Block dimensions
    localparam int MAX_LOCI  = 6;
    localparam int FRAC_BITS = 16;
    localparam int RATE_REGS = MAX_LOCI - 1;
    localparam int ROW_DEPTH = 1 << MAX_LOCI;

    // Field widths
    localparam int GENO_W  = MAX_LOCI;
    localparam int LOCI_W  = 3;
    localparam int RATE_W  = 16;
    localparam int PROB_W  = FRAC_BITS + 1;
    localparam int MASK_W  = MAX_LOCI - 1;
    localparam int GAP_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Q1.16 one, which is also the accumulator ceiling
    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << FRAC_BITS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_LOCI   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LAST  = 3'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_ACC1,
        ST_ACC2,
        ST_EMIT_RD,
        ST_EMIT_LD
    } rrg_state_t;

endpackage

// ----- src/rrg_ram.sv -----
module rrg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (read returns old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/recombination_row_generator_core.sv -----
// Recombination row generator.
// Input channel (in_valid / in_stall) takes a pair of parent genotypes; a request
// is taken when in_valid is high and in_stall is low. in_stall is high while a row
// is being built or emitted, so one pair is worked on at a time.
// Output channel (out_valid / out_stall) returns 2^n results, zygote 0 upward,
// with last set on the final one. The output register holds its result while
// out_stall is high and the sequencer waits on it.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready; index 0 is num_loci, indexes 1..5 are the gap rates. Write it only idle.
// For n loci, each of the 2^(n-1) crossover masks passes the weight through its n-1
// gaps on the single 17x17 multiplier, halves it while reading the first zygote, then
// does one read-modify-write per zygote on the accumulator RAM port. Emission does a
// RAM read and then loads the output register for each result.
// The accumulator row lives in a 64 x 17 RAM; per-entry valid flops are cleared
// when a pair is taken, so an entry not yet written reads as zero.
// Reset clears the sequencer, valid flops, output valid and the registers
// (num_loci = 1, rates = 0).
module recombination_row_generator_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rrg_pkg::GENO_W-1:0]    parent_a,
    input  logic [rrg_pkg::GENO_W-1:0]    parent_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rrg_pkg::GENO_W-1:0]    zygote,
    output logic [rrg_pkg::PROB_W-1:0]    probability,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrg_pkg::RATE_W-1:0]    cfg_data
);

    import rrg_pkg::*;

    // Configuration registers
    logic [LOCI_W-1:0] num_loci_reg;
    logic [RATE_W-1:0] rate_reg [RATE_REGS];

    // Sequencer and datapath registers
    rrg_state_t        state_reg, state_next;
    logic [GENO_W-1:0] a_reg, a_next;
    logic [GENO_W-1:0] b_reg, b_next;
    logic [LOCI_W-1:0] n_reg, n_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic [GAP_W-1:0]  gap_reg, gap_next;
    logic [PROB_W-1:0] w_reg, w_next;
    logic [PROB_W-1:0] sum1_reg, sum1_next;
    logic [GENO_W-1:0] emit_reg, emit_next;
    logic [ROW_DEPTH-1:0] valid_reg, valid_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [GENO_W-1:0] zygote_reg, zygote_next;
    logic [PROB_W-1:0] prob_reg, prob_next;
    logic              last_reg, last_next;

    // RAM port
    logic              ram_we;
    logic [GENO_W-1:0] ram_waddr;
    logic [PROB_W-1:0] ram_wdata;
    logic [GENO_W-1:0] ram_raddr;
    logic [PROB_W-1:0] ram_rdata;

    // Combinational helpers
    logic [LOCI_W-1:0]     n_used;
    logic [GENO_W-1:0]     lmask;
    logic [GENO_W-1:0]     mask_ext;
    logic [GENO_W-1:0]     z1;
    logic [GENO_W-1:0]     z2;
    logic [GAP_W-1:0]      gap_p1;
    logic                  gap_active;
    logic [PROB_W-1:0]     rate_ext;
    logic [PROB_W-1:0]     factor;
    logic [2*PROB_W-1:0]   product;
    logic [MASK_W-1:0]     mask_final;
    logic [GENO_W-1:0]     emit_final;
    logic [PROB_W-1:0]     acc_base;
    logic [PROB_W:0]       acc_sum;
    logic [PROB_W-1:0]     acc_sat;
    logic                  in_take;
    logic                  out_free;

    rrg_ram #(
        .WIDTH (PROB_W),
        .DEPTH (ROW_DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration writes; always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_loci_reg <= LOCI_W'(1);
            for (int i = 0; i < RATE_REGS; i++)
            begin
                rate_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_NUM_LOCI)
            begin
                num_loci_reg <= cfg_data[LOCI_W-1:0];
            end
            else if (cfg_index inside {[REG_RATE_FIRST:REG_RATE_LAST]})
            begin
                rate_reg[cfg_index - REG_RATE_FIRST] <= cfg_data;
            end
        end
    end

    // Loci count clamped to 1..MAX_LOCI
    always_comb
    begin
        if (num_loci_reg == '0)
        begin
            n_used = LOCI_W'(1);
        end
        else if (num_loci_reg > LOCI_W'(MAX_LOCI))
        begin
            n_used = LOCI_W'(MAX_LOCI);
        end
        else
        begin
            n_used = num_loci_reg;
        end
    end

    assign lmask = GENO_W'((GENO_W+1)'(1) << n_used) - GENO_W'(1);

    // Zygotes for the current mask (parents are already limited to n loci)
    assign mask_ext = GENO_W'(mask_reg);
    assign z1 = (a_reg & ~mask_ext) | (b_reg & mask_ext);
    assign z2 = (b_reg & ~mask_ext) | (a_reg & mask_ext);

    // Per-gap factor: rate where the mask bits differ, one minus rate where they match
    assign gap_p1     = gap_reg + GAP_W'(1);
    assign gap_active = gap_p1 < n_reg;
    assign rate_ext   = PROB_W'(rate_reg[gap_reg]);
    assign factor     = (mask_ext[gap_reg] != mask_ext[gap_p1]) ? rate_ext
                                                                : PROB_ONE - rate_ext;
    assign product    = w_reg * factor;

    // Loop bounds for the latched loci count
    assign mask_final = MASK_W'((GENO_W'(1) << (n_reg - LOCI_W'(1))) - GENO_W'(1));
    assign emit_final = GENO_W'(((GENO_W+1)'(1) << n_reg) - (GENO_W+1)'(1));

    // Accumulator update with forwarding when both zygotes hit the same entry
    always_comb
    begin
        if (state_reg == ST_ACC2)
        begin
            if (z2 == z1)
            begin
                acc_base = sum1_reg;
            end
            else
            begin
                acc_base = valid_reg[z2] ? ram_rdata : '0;
            end
        end
        else
        begin
            acc_base = valid_reg[z1] ? ram_rdata : '0;
        end
    end

    assign acc_sum = (PROB_W+1)'(acc_base) + (PROB_W+1)'(w_reg);
    assign acc_sat = (acc_sum > (PROB_W+1)'(PROB_ONE)) ? PROB_ONE : acc_sum[PROB_W-1:0];

    // Handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer state register, entry valid flops and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        n_reg      <= n_next;
        mask_reg   <= mask_next;
        gap_reg    <= gap_next;
        w_reg      <= w_next;
        sum1_reg   <= sum1_next;
        emit_reg   <= emit_next;
        zygote_reg <= zygote_next;
        prob_reg   <= prob_next;
        last_reg   <= last_next;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        n_next         = n_reg;
        mask_next      = mask_reg;
        gap_next       = gap_reg;
        w_next         = w_reg;
        sum1_next      = sum1_reg;
        emit_next      = emit_reg;
        valid_next     = valid_reg;
        zygote_next    = zygote_reg;
        prob_next      = prob_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = z1;
        ram_wdata      = acc_sat;
        ram_raddr      = z1;

        // Output register drains independently of the sequencer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    a_next     = parent_a & lmask;
                    b_next     = parent_b & lmask;
                    n_next     = n_used;
                    mask_next  = '0;
                    gap_next   = '0;
                    w_next     = PROB_ONE;
                    valid_next = '0;
                    state_next = ST_WEIGHT;
                end
            end

            // One gap per cycle, then halve and read the first zygote
            ST_WEIGHT:
            begin
                if (gap_active)
                begin
                    w_next   = product[FRAC_BITS +: PROB_W];
                    gap_next = gap_p1;
                end
                else
                begin
                    w_next     = w_reg >> 1;
                    ram_raddr  = z1;
                    state_next = ST_ACC1;
                end
            end

            // Write first zygote, read second
            ST_ACC1:
            begin
                ram_we          = 1'b1;
                ram_waddr       = z1;
                ram_wdata       = acc_sat;
                valid_next[z1]  = 1'b1;
                sum1_next       = acc_sat;
                ram_raddr       = z2;
                state_next      = ST_ACC2;
            end

            // Write second zygote, move to the next mask or to emission
            ST_ACC2:
            begin
                ram_we         = 1'b1;
                ram_waddr      = z2;
                ram_wdata      = acc_sat;
                valid_next[z2] = 1'b1;
                if (mask_reg == mask_final)
                begin
                    emit_next  = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    mask_next  = mask_reg + MASK_W'(1);
                    gap_next   = '0;
                    w_next     = PROB_ONE;
                    state_next = ST_WEIGHT;
                end
            end

            ST_EMIT_RD:
            begin
                ram_raddr  = emit_reg;
                state_next = ST_EMIT_LD;
            end

            // Load output register once it is free; read data holds meanwhile
            ST_EMIT_LD:
            begin
                ram_raddr = emit_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    zygote_next    = emit_reg;
                    prob_next      = valid_reg[emit_reg] ? ram_rdata : '0;
                    last_next      = (emit_reg == emit_final);
                    if (emit_reg == emit_final)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        emit_next  = emit_reg + GENO_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign zygote      = zygote_reg;
    assign probability = prob_reg;
    assign last        = last_reg;

endmodule

// ----- tb/sv/rrg_row_checker.sv -----
`timescale 1ns / 1ps

// Watches the configuration, parent and zygote channels of the row generator,
// keeps its own copy of the registers, predicts every zygote row and compares.
module rrg_row_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [rrg_pkg::GENO_W-1:0]    parent_a,
    input  logic [rrg_pkg::GENO_W-1:0]    parent_b,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [rrg_pkg::GENO_W-1:0]    zygote,
    input  logic [rrg_pkg::PROB_W-1:0]    probability,
    input  logic                          last,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [rrg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrg_pkg::RATE_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            pending_results,
    output int                            results_checked
);
    import rrg_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [GENO_W-1:0] zygote;
        logic [PROB_W-1:0] probability;
        logic              last;
    } zygote_prob_t;

    // shadow registers
    logic [LOCI_W-1:0] loci_setting;
    logic [RATE_W-1:0] gap_rate [RATE_REGS];

    zygote_prob_t pending_zygotes [$];
    int           error_count;
    int           compared;

    assign mismatches      = error_count;
    assign results_checked = compared;

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t zygote row error: %s", $time, msg);
    endtask

    // Build the whole probability row for one parent pair and queue it
    function automatic void build_zygote_row(input logic [GENO_W-1:0] pa,
                                             input logic [GENO_W-1:0] pb);
        int unsigned       loci;
        int unsigned       mask;
        int unsigned       z;
        int                g;
        int                side;
        logic [GENO_W-1:0] keep;
        logic [GENO_W-1:0] ga;
        logic [GENO_W-1:0] gb;
        logic [GENO_W-1:0] m;
        logic [GENO_W-1:0] zid;
        logic [PROB_W-1:0] rate;
        logic [PROB_W-1:0] factor;
        logic [33:0]       weight;
        logic [33:0]       sum;
        logic [PROB_W-1:0] acc [ROW_DEPTH];
        zygote_prob_t      entry;

        // out-of-range loci codes clamp to 1..MAX_LOCI
        loci = loci_setting;
        if (loci < 1) loci = 1;
        if (loci > MAX_LOCI) loci = MAX_LOCI;
        keep = GENO_W'((1 << loci) - 1);
        ga   = pa & keep;
        gb   = pb & keep;
        for (int k = 0; k < ROW_DEPTH; k++) acc[k] = '0;

        for (mask = 0; mask < (1 << (loci - 1)); mask++) begin
            m      = GENO_W'(mask);
            weight = 34'(PROB_ONE);
            for (g = 0; g + 1 < loci && g < RATE_REGS; g++) begin
                rate = PROB_W'(gap_rate[g]);
                if (rate > PROB_ONE) rate = PROB_ONE;
                factor = (m[g] != m[g+1]) ? rate : PROB_ONE - rate;
                weight = (weight * 34'(factor)) >> FRAC_BITS;
            end
            weight = weight >> 1;
            // straight and mirrored zygote, each saturating at one
            for (side = 0; side < 2; side++) begin
                zid = side ? ((gb & ~m) | (ga & m)) : ((ga & ~m) | (gb & m));
                zid = zid & keep;
                sum = 34'(acc[zid]) + weight;
                if (sum > 34'(PROB_ONE)) sum = 34'(PROB_ONE);
                acc[zid] = sum[PROB_W-1:0];
            end
        end

        for (z = 0; z < (1 << loci); z++) begin
            entry.zygote      = GENO_W'(z);
            entry.probability = acc[z];
            entry.last        = (z + 1 == (1 << loci));
            pending_zygotes.push_back(entry);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        zygote_prob_t want;
        if (!rst_n) begin
            loci_setting = LOCI_W'(1);
            for (int g = 0; g < RATE_REGS; g++) gap_rate[g] = '0;
            pending_zygotes.delete();
            pending_results <= 0;
        end
        else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_NUM_LOCI)
                    loci_setting = cfg_data[LOCI_W-1:0];
                else if (cfg_index >= REG_RATE_FIRST && cfg_index <= REG_RATE_LAST)
                    gap_rate[cfg_index - REG_RATE_FIRST] = cfg_data;
            end

            // accepted parent pair request
            if (in_valid && !in_stall)
                build_zygote_row(parent_a, parent_b);

            // accepted zygote result
            if (out_valid && !out_stall) begin
                if (pending_zygotes.size() == 0) begin
                    flag_error($sformatf("unexpected result zygote=%0d prob=%0d last=%0b",
                                         zygote, probability, last));
                end
                else begin
                    want = pending_zygotes.pop_front();
                    compared++;
                    if (zygote !== want.zygote || probability !== want.probability ||
                        last !== want.last)
                        flag_error($sformatf(
                            "exp zygote=%0d prob=%0d last=%0b, got zygote=%0d prob=%0d last=%0b",
                            want.zygote, want.probability, want.last,
                            zygote, probability, last));
                end
            end

            pending_results <= pending_zygotes.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rrg_pkg::*;

    localparam int ITEM_TARGET = 130;
    localparam int IDLE_LIMIT  = 4000;
    localparam int END_SETTLE  = 40;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [GENO_W-1:0]    parent_a;
    logic [GENO_W-1:0]    parent_b;
    logic                 out_valid;
    logic                 out_stall;
    logic [GENO_W-1:0]    zygote;
    logic [PROB_W-1:0]    probability;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0]    cfg_data;

    int mismatches;
    int pending_results;
    int results_checked;
    int pairs_sent;
    int settings_loaded;
    int idle_cycles;

    stall_mode_t stall_mode;
    int          mode_left;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    recombination_row_generator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .parent_a    (parent_a),
        .parent_b    (parent_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .zygote      (zygote),
        .probability (probability),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    rrg_row_checker row_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .parent_a        (parent_a),
        .parent_b        (parent_b),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .zygote          (zygote),
        .probability     (probability),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    // Receiver stall pattern: switches at random between no, light, heavy and periodic stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_mode <= STALL_NONE;
            mode_left  <= 0;
        end
        else begin
            if (mode_left == 0) begin
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(20, 200);
            end
            else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 25);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 75);
                default:     out_stall <= mode_left[2];
            endcase
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end
        else begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t no handshake for %0d cycles", $time, idle_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one parent pair and hold it until it is taken
    task automatic send_pair(input logic [GENO_W-1:0] a, input logic [GENO_W-1:0] b);
        parent_a <= a;
        parent_b <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pairs_sent++;
    endtask

    task automatic sender_gap(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait until every predicted zygote has come back
    task automatic wait_row_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Drain, then load loci count and all five gap rates, optionally also unused indexes
    task automatic program_block(input logic [LOCI_W-1:0] loci,
                                 input logic [RATE_W-1:0] r0, input logic [RATE_W-1:0] r1,
                                 input logic [RATE_W-1:0] r2, input logic [RATE_W-1:0] r3,
                                 input logic [RATE_W-1:0] r4, input bit touch_unused);
        wait_row_drain();
        write_reg(REG_NUM_LOCI, RATE_W'(loci));
        write_reg(REG_RATE_FIRST, r0);
        write_reg(CFG_IDX_W'(REG_RATE_FIRST + 1), r1);
        write_reg(CFG_IDX_W'(REG_RATE_FIRST + 2), r2);
        write_reg(CFG_IDX_W'(REG_RATE_FIRST + 3), r3);
        write_reg(REG_RATE_LAST, r4);
        // indexes past the last rate have no register behind them
        if (touch_unused) begin
            write_reg(CFG_IDX_W'(REG_RATE_LAST + 1), RATE_W'($urandom));
            write_reg(CFG_IDX_W'(REG_RATE_LAST + 2), 16'hFFFF);
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return RATE_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [GENO_W-1:0] a;
        logic [GENO_W-1:0] b;
        int                burst_left;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        parent_a  <= '0;
        parent_b  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        pairs_sent      = 0;
        settings_loaded = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one locus, rates zero; upper parent bits ignored
        send_pair(6'h00, 6'h00);
        send_pair(6'h01, 6'h00);
        send_pair(6'h3F, 6'h3E);

        // loci code zero acts as one locus
        program_block(3'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pair(6'h3F, 6'h00);

        // loci code seven clamps to six, all rates one half
        program_block(3'd7, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_pair(6'h3F, 6'h00);
        send_pair(6'h2A, 6'h15);
        send_pair(6'h2D, 6'h2D);

        // six loci, no recombination at all
        program_block(3'd6, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_pair(6'h3F, 6'h00);
        send_pair(6'h15, 6'h2A);

        // six loci, rates at the top of the field
        program_block(3'd6, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pair(6'h3F, 6'h00);
        send_pair(6'h00, 6'h3F);
        send_pair(6'h0F, 6'h30);

        // two loci: gaps past the first unused, writes to unused indexes
        program_block(3'd2, 16'h4000, 16'h1234, 16'hFFFF, 16'h0001, 16'h8000, 1'b1);
        send_pair(6'h01, 6'h02);
        send_pair(6'h03, 6'h00);
        send_pair(6'h3E, 6'h02);

        // five loci, rates just off one half, near zero and near full scale
        program_block(3'd5, 16'h8001, 16'h7FFF, 16'h0001, 16'hFFFE, 16'h8000, 1'b0);
        send_pair(6'h1F, 6'h00);
        send_pair(6'h3F, 6'h3F);

        // random phases: new settings, then a burst-and-gap stream of pairs
        burst_left = $urandom_range(1, 6);
        while (pairs_sent < ITEM_TARGET) begin
            program_block(LOCI_W'($urandom_range(0, 7)), pick_rate(), pick_rate(),
                          pick_rate(), pick_rate(), pick_rate(), $urandom_range(0, 7) == 0);
            repeat ($urandom_range(6, 14)) begin
                a = GENO_W'($urandom);
                case ($urandom_range(0, 5))
                    0:       b = a;
                    1:       b = ~a;
                    default: b = GENO_W'($urandom);
                endcase
                send_pair(a, b);
                burst_left--;
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) == 0)
                        sender_gap($urandom_range(50, 450));
                    else
                        sender_gap($urandom_range(1, 20));
                    burst_left = $urandom_range(1, 6);
                end
                else if ($urandom_range(0, 19) == 0) begin
                    wait_row_drain();
                end
            end
        end

        wait_row_drain();
        repeat (END_SETTLE) @(posedge clk);

        $display("Ran %0d parent pairs under %0d register settings, %0d zygote results compared.",
                 pairs_sent, settings_loaded + 1, results_checked);
        $display("Loci counts 0..7, rates from zero to full scale, random stalls and gaps.");
        if (mismatches == 0 && pending_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/rrg_pkg.sv
src/rrg_ram.sv
src/recombination_row_generator_core.sv
tb/sv/rrg_row_checker.sv
tb/sv/testbench.sv
